// File: sv/svie_pkg.sv
// Package with the constants, types and decode helpers of the stack machine executor.
`timescale 1ns / 1ps
package svie_pkg;

   localparam int MEM_WORDS   = 32768;
   localparam int MEM_AW      = $clog2(MEM_WORDS);
   localparam int STACK_DEPTH = 1024;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = STK_AW + 1;
   localparam int WORD_W      = 15;
   localparam int DIV_STEPS   = WORD_W;
   localparam int DIV_CW      = $clog2(DIV_STEPS);

   typedef enum logic [4:0] {
      OP_HALT = 5'd0,  OP_SET  = 5'd1,  OP_PUSH = 5'd2,  OP_POP  = 5'd3,
      OP_EQ   = 5'd4,  OP_GT   = 5'd5,  OP_JMP  = 5'd6,  OP_JT   = 5'd7,
      OP_JF   = 5'd8,  OP_ADD  = 5'd9,  OP_MULT = 5'd10, OP_MOD  = 5'd11,
      OP_AND  = 5'd12, OP_OR   = 5'd13, OP_NOT  = 5'd14, OP_RMEM = 5'd15,
      OP_WMEM = 5'd16, OP_CALL = 5'd17, OP_RET  = 5'd18, OP_OUT  = 5'd19,
      OP_IN   = 5'd20, OP_NOOP = 5'd21
   } opcode_type;

   localparam logic [15:0] OP_LAST = 16'd21;

   typedef enum logic [1:0] {
      STAT_RUN   = 2'd0,
      STAT_HALT  = 2'd1,
      STAT_WAIT  = 2'd2,
      STAT_FAULT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_RD, ST_CAP, ST_EXEC,
      ST_POP_WB, ST_RET_WB, ST_RMEM_WB, ST_DIV, ST_DONE
   } state_type;

   // Number of operand words that follow each opcode.
   function automatic logic [1:0] operand_count(input opcode_type op);
      logic [1:0] n;
      n = 2'd0;
      unique case (op)
         OP_HALT, OP_RET, OP_NOOP:                       n = 2'd0;
         OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN: n = 2'd1;
         OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM:  n = 2'd2;
         default:                                        n = 2'd3;
      endcase
      return n;
   endfunction

endpackage

// File: sv/stack_vm_instruction_executor_unit.sv
// Top level of the fifteen-bit, eight-register stack machine instruction executor.
`timescale 1ns / 1ps
// Usage: the request channel (req_valid / req_stall) carries one item at a time.
// A load item (req_cmd = 0) writes req_load_data into program memory at
// req_load_addr. A step item (req_cmd = 1) fetches and executes one instruction
// at the program counter; req_in_valid and req_in_char offer a character to IN.
// Every item returns exactly one item on the response channel (rsp_valid /
// rsp_stall) with the status, any OUT character, whether the input character was
// taken, and the program counter after the item.
// Sequencing: a load item writes memory in ST_LOAD and then goes to ST_DONE; a
// step item on a stopped machine goes straight to ST_DONE. A step item reads
// each instruction word on the single program memory port in ST_RD and
// captures and decodes it in ST_CAP, then executes in ST_EXEC, takes a write
// back state for POP, RET and RMEM (stack or memory read), waits in ST_DIV for
// MOD in the bit-serial remainder unit, and registers the result in ST_DONE.
// req_stall stays high from acceptance until the result is registered, and
// the next item can be taken in the cycle after that.
// Reset clears the registers, program counter, stack pointer and the halt and
// fault flags; program memory and the stack are not cleared and must be loaded
// before use. While the receiver stalls, the result is held in the output
// register and the next item can already be accepted and worked on; it then
// waits for the output register to empty.
module stack_vm_instruction_executor_unit
   import svie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [14:0] req_load_addr,
   input  logic [15:0] req_load_data,
   input  logic        req_in_valid,
   input  logic [7:0]  req_in_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_in_taken,
   output logic [14:0] rsp_next_pc
);

   // Sequencer and architectural state.
   state_type         state_ff, state_in;
   logic [MEM_AW-1:0] pc_ff, pc_in;
   logic [MEM_AW-1:0] p_ff, p_in;
   logic              halted_ff, halted_in;
   logic              fault_ff, fault_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [WORD_W-1:0] regs_ff [8];

   // Decoded instruction.
   opcode_type        op_ff, op_in;
   logic [1:0]        idx_ff, idx_in;
   logic [1:0]        need_ff, need_in;
   logic [WORD_W-1:0] val_ff [3];
   logic [2:0]        srcok_ff, srcok_in;
   logic [2:0]        dst_ff, dst_in;
   logic              dstok_ff, dstok_in;
   logic              opnd_we;

   // Latched request.
   logic              cmd_ff;
   logic [14:0]       laddr_ff;
   logic [15:0]       ldata_ff;
   logic              inv_ff;
   logic [7:0]        inch_ff;

   // Result under construction and the output register.
   status_type        res_status_ff, res_status_in;
   logic              res_outv_ff, res_outv_in;
   logic [7:0]        res_outc_ff, res_outc_in;
   logic              res_intk_ff, res_intk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic              rsp_outv_ff, rsp_intk_ff;
   logic [7:0]        rsp_outc_ff;
   logic [14:0]       rsp_pc_ff;
   logic              rsp_load;

   // Memories and write ports.
   logic [15:0]       mem [MEM_WORDS];
   logic [15:0]       mem_q;
   logic [MEM_AW-1:0] mem_addr;
   logic              mem_we;
   logic [15:0]       mem_wd;
   logic [WORD_W-1:0] stk [STACK_DEPTH];
   logic [WORD_W-1:0] stk_q;
   logic [STK_AW-1:0] stk_addr;
   logic              stk_we;
   logic [WORD_W-1:0] stk_wd;
   logic              reg_we;
   logic [2:0]        reg_wa;
   logic [WORD_W-1:0] reg_wd;

   logic              div_start, div_done;
   logic [WORD_W-1:0] div_rem;
   logic              accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   svie_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (val_ff[1]),
      .divisor   (val_ff[2]),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      mem_q <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk[stk_addr] <= stk_wd;
      end
      stk_q <= stk[stk_addr];
   end

   always_comb begin
      logic [15:0]       w;
      logic              w_reg, w_src;
      logic [WORD_W-1:0] b, c;
      logic [29:0]       prod;
      logic              ok;
      logic              stk_room;

      state_in      = state_ff;
      pc_in         = pc_ff;
      p_in          = p_ff;
      halted_in     = halted_ff;
      fault_in      = fault_ff;
      sp_in         = sp_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      need_in       = need_ff;
      srcok_in      = srcok_ff;
      dst_in        = dst_ff;
      dstok_in      = dstok_ff;
      opnd_we       = 1'b0;
      res_status_in = res_status_ff;
      res_outv_in   = res_outv_ff;
      res_outc_in   = res_outc_ff;
      res_intk_in   = res_intk_ff;
      mem_addr      = p_ff;
      mem_we        = 1'b0;
      mem_wd        = ldata_ff;
      stk_addr      = sp_ff[STK_AW-1:0];
      stk_we        = 1'b0;
      stk_wd        = val_ff[0];
      reg_we        = 1'b0;
      reg_wa        = dst_ff;
      reg_wd        = val_ff[1];
      div_start     = 1'b0;
      rsp_load      = 1'b0;

      // Operand word decode from the memory read data.
      w     = mem_q;
      w_reg = w[15] && (w[14:3] == 12'd0);
      w_src = !w[15] || w_reg;

      b        = val_ff[1];
      c        = val_ff[2];
      prod     = b * c;
      stk_room = sp_ff < SP_W'(STACK_DEPTH);
      ok       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_outv_in = 1'b0;
               res_outc_in = 8'd0;
               res_intk_in = 1'b0;
               res_status_in = fault_ff ? STAT_FAULT : (halted_ff ? STAT_HALT : STAT_RUN);
               idx_in = 2'd0;
               p_in   = pc_ff;
               if (!req_cmd) begin
                  state_in = ST_LOAD;
               end else if (halted_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_LOAD: begin
            mem_addr = laddr_ff;
            mem_we   = 1'b1;
            state_in = ST_DONE;
         end
         ST_RD: begin
            mem_addr = p_ff;
            p_in     = p_ff + 1'b1;
            state_in = ST_CAP;
         end
         ST_CAP: begin
            if (idx_ff == 2'd0) begin
               if (w > OP_LAST) begin
                  halted_in     = 1'b1;
                  fault_in      = 1'b1;
                  res_status_in = STAT_FAULT;
                  state_in      = ST_DONE;
               end else begin
                  op_in   = opcode_type'(w[4:0]);
                  need_in = operand_count(opcode_type'(w[4:0]));
                  idx_in  = 2'd1;
                  state_in = (operand_count(opcode_type'(w[4:0])) == 2'd0) ? ST_EXEC : ST_RD;
               end
            end else begin
               opnd_we = 1'b1;
               srcok_in[idx_ff - 2'd1] = w_src;
               if (idx_ff == 2'd1) begin
                  dst_in   = w[2:0];
                  dstok_in = w_reg;
               end
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == need_ff) ? ST_EXEC : ST_RD;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (op_ff)
               OP_HALT: begin
                  halted_in     = 1'b1;
                  res_status_in = STAT_HALT;
               end
               OP_SET, OP_NOT, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_AND, OP_OR: begin
                  ok = dstok_ff && srcok_ff[1];
                  if (op_ff != OP_SET && op_ff != OP_NOT) begin
                     ok = ok && srcok_ff[2];
                  end
                  reg_we = ok;
                  case (op_ff)
                     OP_SET:  reg_wd = b;
                     OP_NOT:  reg_wd = ~b;
                     OP_EQ:   reg_wd = WORD_W'(b == c);
                     OP_GT:   reg_wd = WORD_W'(b > c);
                     OP_ADD:  reg_wd = b + c;
                     OP_MULT: reg_wd = prod[WORD_W-1:0];
                     OP_AND:  reg_wd = b & c;
                     default: reg_wd = b | c;
                  endcase
                  if (ok) pc_in = p_ff;
               end
               OP_MOD: begin
                  ok = dstok_ff && srcok_ff[1] && srcok_ff[2] && (c != '0);
                  if (ok) begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               OP_RMEM: begin
                  ok       = dstok_ff && srcok_ff[1];
                  mem_addr = b;
                  if (ok) state_in = ST_RMEM_WB;
               end
               OP_WMEM: begin
                  ok       = srcok_ff[0] && srcok_ff[1];
                  mem_addr = val_ff[0];
                  mem_wd   = {1'b0, b};
                  mem_we   = ok;
                  if (ok) pc_in = p_ff;
               end
               OP_PUSH, OP_CALL: begin
                  ok       = srcok_ff[0] && stk_room;
                  stk_we   = ok;
                  stk_wd   = (op_ff == OP_PUSH) ? val_ff[0] : p_ff;
                  if (ok) begin
                     sp_in = sp_ff + 1'b1;
                     pc_in = (op_ff == OP_PUSH) ? p_ff : val_ff[0];
                  end
               end
               OP_POP: begin
                  ok       = dstok_ff && (sp_ff != '0);
                  stk_addr = STK_AW'(sp_ff - 1'b1);
                  if (ok) state_in = ST_POP_WB;
               end
               OP_RET: begin
                  stk_addr = STK_AW'(sp_ff - 1'b1);
                  if (sp_ff == '0) begin
                     halted_in     = 1'b1;
                     res_status_in = STAT_HALT;
                  end else begin
                     state_in = ST_RET_WB;
                  end
               end
               OP_JMP: begin
                  ok = srcok_ff[0];
                  if (ok) pc_in = val_ff[0];
               end
               OP_JT, OP_JF: begin
                  ok = srcok_ff[0] && srcok_ff[1];
                  if (ok) pc_in = (((op_ff == OP_JT) == (b != '0))) ? val_ff[0] : p_ff;
               end
               OP_OUT: begin
                  ok = srcok_ff[0];
                  if (ok) begin
                     res_outv_in = 1'b1;
                     res_outc_in = val_ff[0][7:0];
                     pc_in       = p_ff;
                  end
               end
               OP_IN: begin
                  ok     = dstok_ff;
                  reg_wd = {7'd0, inch_ff};
                  if (ok) begin
                     if (inv_ff) begin
                        reg_we      = 1'b1;
                        res_intk_in = 1'b1;
                        pc_in       = p_ff;
                     end else begin
                        res_status_in = STAT_WAIT;
                     end
                  end
               end
               default: begin
                  pc_in = p_ff;
               end
            endcase
            if (!ok) begin
               halted_in     = 1'b1;
               fault_in      = 1'b1;
               res_status_in = STAT_FAULT;
            end
         end
         ST_POP_WB: begin
            reg_we   = 1'b1;
            reg_wd   = stk_q;
            sp_in    = sp_ff - 1'b1;
            pc_in    = p_ff;
            state_in = ST_DONE;
         end
         ST_RET_WB: begin
            sp_in    = sp_ff - 1'b1;
            pc_in    = stk_q;
            state_in = ST_DONE;
         end
         ST_RMEM_WB: begin
            reg_we   = 1'b1;
            reg_wd   = mem_q[WORD_W-1:0];
            pc_in    = p_ff;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (div_done) begin
               reg_we   = 1'b1;
               reg_wd   = div_rem;
               pc_in    = p_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         fault_ff     <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         fault_ff     <= fault_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_we) begin
            regs_ff[reg_wa] <= reg_wd;
         end
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      need_ff       <= need_in;
      srcok_ff      <= srcok_in;
      dst_ff        <= dst_in;
      dstok_ff      <= dstok_in;
      res_status_ff <= res_status_in;
      res_outv_ff   <= res_outv_in;
      res_outc_ff   <= res_outc_in;
      res_intk_ff   <= res_intk_in;
      if (opnd_we) begin
         val_ff[idx_ff - 2'd1] <= mem_q[15] ? regs_ff[mem_q[2:0]] : mem_q[14:0];
      end
      if (accept) begin
         cmd_ff   <= req_cmd;
         laddr_ff <= req_load_addr;
         ldata_ff <= req_load_data;
         inv_ff   <= req_in_valid;
         inch_ff  <= req_in_char;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_outv_ff   <= res_outv_ff;
         rsp_outc_ff   <= res_outc_ff;
         rsp_intk_ff   <= res_intk_ff;
         rsp_pc_ff     <= cmd_ff ? pc_ff : pc_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_valid = rsp_outv_ff;
   assign rsp_out_char  = rsp_outc_ff;
   assign rsp_in_taken  = rsp_intk_ff;
   assign rsp_next_pc   = rsp_pc_ff;

endmodule

// File: sv/svie_div.sv
// Restoring remainder unit: one quotient bit per cycle for the MOD instruction.
`timescale 1ns / 1ps
module svie_div
   import svie_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [WORD_W-1:0] divisor,
   output logic              done,
   output logic [WORD_W-1:0] remainder
);

   logic              busy_ff, done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [WORD_W-1:0] rem_ff, dvd_ff, dsr_ff;
   logic [WORD_W:0]   trial;
   logic              last_step;

   assign trial     = {rem_ff, dvd_ff[WORD_W-1]};
   assign last_step = busy_ff && (cnt_ff == DIV_CW'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_ff <= WORD_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_ff <= trial[WORD_W-1:0];
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/svie_checker.sv
// Port-level checker for the stack machine executor and its bind statement.
`timescale 1ns / 1ps
module svie_checker
   import svie_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_out_valid,
   input logic [7:0]  rsp_out_char,
   input logic        rsp_in_taken
);

   // A stalled result holds its status.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

   // Only one item is in work at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while busy");

   // A character is emitted only by an instruction that ran to completion.
   a_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == STAT_RUN && !rsp_in_taken)
      else $error("output character with a stop status");

   // No stray character without an emission.
   a_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_char == 8'd0)
      else $error("character without emission");

   // Input is taken only by a completed instruction.
   a_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_taken |-> rsp_status == STAT_RUN)
      else $error("input taken with a stop status");

endmodule

bind stack_vm_instruction_executor_unit svie_checker u_svie_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_out_valid (rsp_out_valid),
   .rsp_out_char  (rsp_out_char),
   .rsp_in_taken  (rsp_in_taken)
);

// File: dv/stack_vm_instruction_executor_unit_tb.sv
// Testbench for the stack machine executor: directed program, random programs, fault at the end.
`timescale 1ns / 1ps
module stack_vm_instruction_executor_unit_tb;
   import svie_pkg::*;

   // Operand word that names register 0; registers 1..7 follow it.
   localparam logic [15:0] REG0       = 16'h8000;
   localparam int          IDLE_LIMIT = 4000;
   localparam int          RAND_ITEMS = 1300;

   typedef struct packed {
      logic [1:0]  status;
      logic        out_valid;
      logic [7:0]  out_char;
      logic        in_taken;
      logic [14:0] next_pc;
   } vm_result_type;

   // One directed instruction: opcode, up to three operand words, offered input.
   typedef struct {
      opcode_type    op;
      logic [15:0]   wa, wb, wc;
      bit            iv;
      logic [7:0]    ic;
      bit            typed;
      vm_result_type exp;
   } vm_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = 1'b0;
   logic [14:0] req_load_addr = '0;
   logic [15:0] req_load_data = '0;
   logic        req_in_valid = 1'b0;
   logic [7:0]  req_in_char = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_out_valid;
   logic [7:0]  rsp_out_char;
   logic        rsp_in_taken;
   logic [14:0] rsp_next_pc;

   stack_vm_instruction_executor_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_load_addr (req_load_addr),
      .req_load_data (req_load_data),
      .req_in_valid  (req_in_valid),
      .req_in_char   (req_in_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_char  (rsp_out_char),
      .rsp_in_taken  (rsp_in_taken),
      .rsp_next_pc   (rsp_next_pc)
   );

   always #5 clock = ~clock;

   // Shadow machine state. The written map keeps every rmem source on a loaded word.
   logic [15:0] vm_mem [MEM_WORDS];
   bit          vm_written [MEM_WORDS];
   logic [14:0] vm_regs [8];
   logic [14:0] vm_stack [STACK_DEPTH];
   logic [14:0] vm_pc;
   int          vm_sp;
   bit          vm_halted, vm_faulted;

   vm_result_type vm_results_due[$];
   int            fail_count;
   int            idle_cycles;
   int            burst_left;
   int            items_sent;

   // Operand words that follow each opcode, indexed by opcode.
   localparam int ARG_WORDS [22] = '{0, 2, 1, 1, 3, 3, 1, 2, 2, 3, 3,
                                     3, 3, 3, 2, 2, 2, 1, 0, 1, 1, 0};

   function automatic bit read_src(input logic [15:0] w, output logic [14:0] v);
      v = '0;
      if (w < REG0) begin
         v = w[14:0];
         return 1'b1;
      end
      if (w < REG0 + 16'd8) begin
         v = vm_regs[w[2:0]];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit read_dst(input logic [15:0] w, output logic [2:0] rd);
      rd = w[2:0];
      return (w >= REG0) && (w < REG0 + 16'd8);
   endfunction

   function automatic logic [1:0] stop_code();
      return vm_faulted ? STAT_FAULT : (vm_halted ? STAT_HALT : STAT_RUN);
   endfunction

   // Applies one item to the shadow machine and returns the result it must produce.
   function automatic vm_result_type vm_execute(input bit cmd, input logic [14:0] la,
                                                input logic [15:0] ld, input bit iv,
                                                input logic [7:0] ic);
      vm_result_type r;
      logic [14:0]   p, a, b, c, v;
      logic [15:0]   opw;
      logic [15:0]   w [3];
      logic [29:0]   prod;
      logic [2:0]    rd;
      bit            ok, commit;
      r = '0;
      ok = 1'b1;
      commit = 1'b1;
      a = '0; b = '0; c = '0; v = '0; rd = '0;
      w[0] = '0; w[1] = '0; w[2] = '0;
      if (!cmd) begin
         vm_mem[la] = ld;
         vm_written[la] = 1'b1;
         r.status = stop_code();
      end else if (vm_halted) begin
         r.status = stop_code();
      end else begin
         p = vm_pc;
         opw = vm_mem[p];
         p = p + 15'd1;
         if (opw > OP_LAST) begin
            ok = 1'b0;
         end else begin
            for (int i = 0; i < ARG_WORDS[opw]; i++) begin
               w[i] = vm_mem[p];
               p = p + 15'd1;
            end
         end
         if (ok) begin
            case (opcode_type'(opw[4:0]))
               OP_HALT: begin
                  r.status = STAT_HALT;
                  vm_halted = 1'b1;
                  commit = 1'b0;
               end
               OP_SET, OP_NOT, OP_RMEM: begin
                  ok = read_dst(w[0], rd) && read_src(w[1], b);
                  if (ok) begin
                     if (opw[4:0] == OP_SET) vm_regs[rd] = b;
                     else if (opw[4:0] == OP_NOT) vm_regs[rd] = ~b;
                     else vm_regs[rd] = vm_mem[b][14:0];
                  end
               end
               OP_PUSH: begin
                  ok = read_src(w[0], a) && (vm_sp < STACK_DEPTH);
                  if (ok) begin
                     vm_stack[vm_sp] = a;
                     vm_sp++;
                  end
               end
               OP_POP: begin
                  ok = read_dst(w[0], rd) && (vm_sp > 0);
                  if (ok) begin
                     vm_sp--;
                     vm_regs[rd] = vm_stack[vm_sp];
                  end
               end
               OP_JMP: begin
                  ok = read_src(w[0], a);
                  if (ok) p = a;
               end
               OP_JT, OP_JF: begin
                  ok = read_src(w[0], a) && read_src(w[1], b);
                  if (ok && ((opw[4:0] == OP_JT) == (b != 0))) p = a;
               end
               OP_WMEM: begin
                  ok = read_src(w[0], a) && read_src(w[1], b);
                  if (ok) begin
                     vm_mem[a] = {1'b0, b};
                     vm_written[a] = 1'b1;
                  end
               end
               OP_CALL: begin
                  ok = read_src(w[0], a) && (vm_sp < STACK_DEPTH);
                  if (ok) begin
                     vm_stack[vm_sp] = p;
                     vm_sp++;
                     p = a;
                  end
               end
               OP_RET: begin
                  if (vm_sp == 0) begin
                     r.status = STAT_HALT;
                     vm_halted = 1'b1;
                     commit = 1'b0;
                  end else begin
                     vm_sp--;
                     p = vm_stack[vm_sp];
                  end
               end
               OP_OUT: begin
                  ok = read_src(w[0], a);
                  if (ok) begin
                     r.out_valid = 1'b1;
                     r.out_char = a[7:0];
                  end
               end
               OP_IN: begin
                  ok = read_dst(w[0], rd);
                  if (ok) begin
                     if (iv) begin
                        vm_regs[rd] = {7'd0, ic};
                        r.in_taken = 1'b1;
                     end else begin
                        r.status = STAT_WAIT;
                        commit = 1'b0;
                     end
                  end
               end
               OP_NOOP: ;
               default: begin
                  // Three-operand arithmetic and compares.
                  ok = read_dst(w[0], rd) && read_src(w[1], b) && read_src(w[2], c);
                  if (ok && opw[4:0] == OP_MOD && c == 0) ok = 1'b0;
                  if (ok) begin
                     prod = b * c;
                     case (opcode_type'(opw[4:0]))
                        OP_EQ:   v = (b == c) ? 15'd1 : 15'd0;
                        OP_GT:   v = (b > c) ? 15'd1 : 15'd0;
                        OP_ADD:  v = b + c;
                        OP_MULT: v = prod[14:0];
                        OP_MOD:  v = b % c;
                        OP_AND:  v = b & c;
                        default: v = b | c;
                     endcase
                     vm_regs[rd] = v;
                  end
               end
            endcase
         end
         if (!ok) begin
            vm_halted = 1'b1;
            vm_faulted = 1'b1;
            r.status = STAT_FAULT;
            commit = 1'b0;
         end
         if (commit) vm_pc = p;
      end
      r.next_pc = vm_pc;
      return r;
   endfunction

   // Predicts one item, then offers it under the burst and gap pattern until it is taken.
   task automatic drive_item(input bit cmd, input logic [14:0] la, input logic [15:0] ld,
                             input bit iv, input logic [7:0] ic, input bit typed,
                             input vm_result_type typed_exp);
      vm_result_type e;
      int            gap;
      e = vm_execute(cmd, la, ld, iv, ic);
      vm_results_due.push_back(typed ? typed_exp : e);
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_load_addr <= la;
      req_load_data <= ld;
      req_in_valid  <= iv;
      req_in_char   <= ic;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_word(input logic [14:0] la, input logic [15:0] ld);
      drive_item(1'b0, la, ld, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'b0, '0);
   endtask

   // Places an instruction at the program counter, makes sure an rmem source is
   // loaded, and then steps it.
   task automatic run_instr(input opcode_type op, input logic [15:0] wa, input logic [15:0] wb,
                            input logic [15:0] wc, input bit iv, input logic [7:0] ic,
                            input bit typed, input vm_result_type typed_exp);
      logic [15:0] words [4];
      logic [14:0] src_addr;
      words[0] = {11'd0, op};
      words[1] = wa;
      words[2] = wb;
      words[3] = wc;
      for (int i = 0; i <= ARG_WORDS[op]; i++) load_word(vm_pc + 15'(i), words[i]);
      if (op == OP_RMEM && read_src(wb, src_addr) && !vm_written[src_addr])
         load_word(src_addr, 16'($urandom));
      drive_item(1'b1, 15'($urandom), 16'($urandom), iv, ic, typed, typed_exp);
   endtask

   function automatic logic [15:0] pick_src();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'd32767;
         2, 3:    return REG0 + 16'($urandom_range(0, 7));
         default: return 16'($urandom_range(0, 32767));
      endcase
   endfunction

   function automatic logic [15:0] pick_dst();
      return REG0 + 16'($urandom_range(0, 7));
   endfunction

   // Directed program from address zero. The first two rows are checked against typed values.
   vm_row_type dir_rows [] = '{
      '{OP_SET,  REG0,      16'd32767, 16'd0,     0, 8'd0,  1, '{STAT_RUN, 0, 8'd0, 0, 15'd3}},
      '{OP_ADD,  REG0 + 1,  REG0,      16'd1,     0, 8'd0,  1, '{STAT_RUN, 0, 8'd0, 0, 15'd7}},
      '{OP_MULT, REG0 + 2,  REG0,      REG0,      0, 8'd0,  0, '0},
      '{OP_MOD,  REG0 + 3,  REG0,      16'd7,     0, 8'd0,  0, '0},
      '{OP_NOT,  REG0 + 4,  16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_AND,  REG0 + 5,  REG0,      16'd21845, 0, 8'd0,  0, '0},
      '{OP_OR,   REG0 + 6,  16'd0,     16'd16384, 0, 8'd0,  0, '0},
      '{OP_EQ,   REG0 + 7,  REG0 + 1,  16'd0,     0, 8'd0,  0, '0},
      '{OP_GT,   REG0 + 7,  REG0,      REG0 + 1,  0, 8'd0,  0, '0},
      '{OP_OUT,  REG0,      16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_OUT,  16'd0,     16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_IN,   REG0 + 2,  16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_IN,   REG0 + 2,  16'd0,     16'd0,     1, 8'd255, 0, '0},
      '{OP_PUSH, REG0,      16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_POP,  REG0 + 3,  16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_WMEM, 16'd32000, REG0,      16'd0,     0, 8'd0,  0, '0},
      '{OP_RMEM, REG0 + 4,  16'd32000, 16'd0,     0, 8'd0,  0, '0},
      '{OP_JT,   16'd200,   REG0 + 1,  16'd0,     0, 8'd0,  0, '0},
      '{OP_JF,   16'd200,   REG0 + 1,  16'd0,     0, 8'd0,  0, '0},
      '{OP_CALL, 16'd32767, 16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_NOOP, 16'd0,     16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_RET,  16'd0,     16'd0,     16'd0,     0, 8'd0,  0, '0},
      '{OP_JMP,  REG0 + 6,  16'd0,     16'd0,     0, 8'd0,  0, '0}
   };

   // Receiver stall pattern: the mode rotates through no stall, random, periodic and sparse stall.
   int unsigned stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      case (stall_phase[8:7])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_stall <= (stall_phase[3:0] < 4'd6);
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Every accepted result is checked field by field against the oldest expectation.
   always @(posedge clock) begin
      vm_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (vm_results_due.size() == 0) begin
            $error("result with nothing expected: status %0d pc %0d", rsp_status, rsp_next_pc);
            fail_count++;
         end else begin
            e = vm_results_due.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_out_valid !== e.out_valid) begin
               $error("out_valid expected %0d actual %0d", e.out_valid, rsp_out_valid);
               fail_count++;
            end
            if (rsp_out_char !== e.out_char) begin
               $error("out_char expected %0h actual %0h", e.out_char, rsp_out_char);
               fail_count++;
            end
            if (rsp_in_taken !== e.in_taken) begin
               $error("in_taken expected %0d actual %0d", e.in_taken, rsp_in_taken);
               fail_count++;
            end
            if (rsp_next_pc !== e.next_pc) begin
               $error("next_pc expected %0d actual %0d", e.next_pc, rsp_next_pc);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long without either handshake ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      opcode_type    op;
      logic [15:0]   wa, wb, wc;
      logic [14:0]   cval;
      vm_result_type fault_exp;
      int            iter;
      fail_count = 0;
      idle_cycles = 0;
      burst_left = 0;
      items_sent = 0;
      for (int i = 0; i < 8; i++) vm_regs[i] = '0;
      vm_pc = '0;
      vm_sp = 0;
      vm_halted = 1'b0;
      vm_faulted = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         run_instr(dir_rows[i].op, dir_rows[i].wa, dir_rows[i].wb, dir_rows[i].wc,
                   dir_rows[i].iv, dir_rows[i].ic, dir_rows[i].typed, dir_rows[i].exp);

      // Random programs are built one instruction at a time at the program counter.
      // Halts, faults and stack misuse are steered away so the machine keeps running.
      iter = 0;
      while (items_sent < RAND_ITEMS) begin
         iter++;
         if (iter == 150) begin
            // Hold the sender off until the block has drained completely.
            req_valid <= 1'b0;
            while (vm_results_due.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0) load_word(15'($urandom), 16'($urandom));
         op = opcode_type'($urandom_range(1, 21));
         if ((op == OP_POP || op == OP_RET) && vm_sp == 0) op = OP_PUSH;
         if ((op == OP_PUSH || op == OP_CALL) && vm_sp >= STACK_DEPTH) op = OP_POP;
         wa = pick_src();
         wb = pick_src();
         wc = pick_src();
         case (op)
            OP_SET, OP_NOT, OP_RMEM, OP_POP, OP_IN,
            OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR: wa = pick_dst();
            default: ;
         endcase
         if (op == OP_MOD && read_src(wc, cval) && cval == 0)
            wc = 16'($urandom_range(1, 32767));
         run_instr(op, wa, wb, wc, ($urandom_range(0, 9) < 7), 8'($urandom_range(0, 255)),
                   1'b0, '0);
      end

      // Bad opcode with every bit set: the machine faults and stays stopped.
      fault_exp = '{STAT_FAULT, 1'b0, 8'd0, 1'b0, vm_pc};
      load_word(vm_pc, 16'hFFFF);
      drive_item(1'b1, '0, '0, 1'b1, 8'd0, 1'b1, fault_exp);
      drive_item(1'b1, '1, '1, 1'b0, 8'd255, 1'b1, fault_exp);
      drive_item(1'b0, 15'd12345, 16'd1, 1'b0, 8'd0, 1'b1, fault_exp);
      req_valid <= 1'b0;

      while (vm_results_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
sv/svie_pkg.sv
sv/svie_div.sv
sv/stack_vm_instruction_executor_unit.sv
sv/svie_checker.sv
dv/stack_vm_instruction_executor_unit_tb.sv
